// ===== design/ildr_pkg.sv =====
// Shared types and constants for the integer-literal-to-double rewriter.
`timescale 1ns / 1ps

package ildr_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_E_LO   = 8'h65;
  localparam logic [7:0] CH_E_UP   = 8'h45;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_Z_LO   = 8'h7A;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_Z_UP   = 8'h5A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       expand;
  } item_t;

  typedef struct packed {
    logic block_cmt;
    logic line_cmt;
    logic str;
    logic chr;
    logic num;
    logic ident;
    logic exp_seen;
    logic pt_seen;
  } flags_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD
  } phase_t;

endpackage

// ===== design/int_literal_to_double_rewriter_unit.sv =====
// Top level of the integer-literal-to-double rewriter.
// Input channel: in_valid/in_ready with in_char, one C source byte per transaction.
// Output channel: out_valid/out_ready with out_char and out_last.
// Every input byte is echoed. When the byte ends an integer literal that had no
// exponent letter and no point, ".0" is sent first, so one input gives one or
// three output transactions; out_last marks the final byte of each group.
// An accepted byte is written into the queue and is offered on the output once it reaches the queue head.
// Throughput: one input byte per cycle while the queue is not full and the output takes
// one byte per cycle; an expanded byte holds the emitter for its three output bytes.
// A queue of QueueDepth entries parts the front end from the emitter; in_ready
// drops only when it is full, so output stalls back up into the input after
// QueueDepth bytes.
// Reset (rst_n low, synchronous) clears all lexical flags, the previous byte,
// the queue and the emitter phase. An integer still open when the stream stops
// never receives its ".0".
`timescale 1ns / 1ps

module int_literal_to_double_rewriter_unit #(
  parameter int QueueDepth = ildr_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last
);

  ildr_pkg::item_t push_item, head_item;
  logic            push, full, pop, head_valid;

  ildr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char),
    .q_full   (full),
    .q_push   (push),
    .q_item   (push_item)
  );

  ildr_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  ildr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_item    (head_item),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

// ===== design/ildr_front.sv =====
// Front end: accepts source bytes, tracks lexical regions, tags bytes that end an integer with no exponent or point.
`timescale 1ns / 1ps

module ildr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_char,
  input  logic          q_full,
  output logic          q_push,
  output ildr_pkg::item_t q_item
);

  ildr_pkg::flags_t flags_r, flags_nxt;
  logic [7:0]       prev_r, prev_nxt;
  logic             expand;
  logic             is_letter, is_digit, prev_e;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  always_comb begin
    is_letter = ((in_char >= ildr_pkg::CH_A_LO) && (in_char <= ildr_pkg::CH_Z_LO)) ||
                ((in_char >= ildr_pkg::CH_A_UP) && (in_char <= ildr_pkg::CH_Z_UP));
    is_digit  = (in_char >= ildr_pkg::CH_ZERO) && (in_char <= ildr_pkg::CH_NINE);
    prev_e    = (prev_r == ildr_pkg::CH_E_LO) || (prev_r == ildr_pkg::CH_E_UP);
  end

  always_comb begin
    flags_nxt = flags_r;
    prev_nxt  = in_char;
    expand    = 1'b0;
    priority if (flags_r.block_cmt) begin
      if ((prev_r == ildr_pkg::CH_STAR) && (in_char == ildr_pkg::CH_SLASH))
        flags_nxt.block_cmt = 1'b0;
    end else if (flags_r.line_cmt) begin
      if ((prev_r != ildr_pkg::CH_BSLASH) && (in_char == ildr_pkg::CH_NL))
        flags_nxt.line_cmt = 1'b0;
    end else if (flags_r.str) begin
      if (in_char == ildr_pkg::CH_DQUOTE) flags_nxt.str = 1'b0;
    end else if (flags_r.chr) begin
      if (in_char == ildr_pkg::CH_SQUOTE) flags_nxt.chr = 1'b0;
    end else if ((prev_r == ildr_pkg::CH_SLASH) && (in_char == ildr_pkg::CH_STAR)) begin
      flags_nxt.block_cmt = 1'b1;
      prev_nxt            = ildr_pkg::CH_NUL;
    end else if ((prev_r == ildr_pkg::CH_SLASH) && (in_char == ildr_pkg::CH_SLASH)) begin
      flags_nxt.line_cmt = 1'b1;
    end else if (in_char == ildr_pkg::CH_DQUOTE) begin
      flags_nxt.str = 1'b1;
    end else if (in_char == ildr_pkg::CH_SQUOTE) begin
      flags_nxt.chr = 1'b1;
    end else if (!flags_r.num && !flags_r.ident && is_letter) begin
      flags_nxt.ident = 1'b1;
    end else if (flags_r.ident && !(is_letter || is_digit)) begin
      flags_nxt.ident = 1'b0;
    end else if (!flags_r.num && !flags_r.ident && is_digit &&
                 (prev_r != ildr_pkg::CH_DOT)) begin
      flags_nxt.num      = 1'b1;
      flags_nxt.pt_seen  = 1'b0;
      flags_nxt.exp_seen = 1'b0;
    end else if (flags_r.num) begin
      priority if (is_digit) begin
        flags_nxt.num = 1'b1;
      end else if ((in_char == ildr_pkg::CH_E_LO) || (in_char == ildr_pkg::CH_E_UP)) begin
        flags_nxt.exp_seen = 1'b1;
      end else if (in_char == ildr_pkg::CH_DOT) begin
        flags_nxt.pt_seen = 1'b1;
      end else if (prev_e &&
                   ((in_char == ildr_pkg::CH_PLUS) || (in_char == ildr_pkg::CH_MINUS))) begin
        flags_nxt.num = 1'b1;
      end else begin
        expand        = !flags_r.exp_seen && !flags_r.pt_seen;
        flags_nxt.num = 1'b0;
      end
    end else begin
      flags_nxt = flags_r;
    end
  end

  always_comb begin
    q_item.ch     = in_char;
    q_item.expand = expand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      prev_r  <= '0;
    end else if (q_push) begin
      flags_r <= flags_nxt;
      prev_r  <= prev_nxt;
    end
  end

endmodule

// ===== design/ildr_queue.sv =====
// Short FIFO between the front end and the emitter.
`timescale 1ns / 1ps

module ildr_queue #(
  parameter int Depth = ildr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ildr_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output ildr_pkg::item_t head_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ildr_pkg::item_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_pop;

  assign full       = (count_r == CntW'(Depth));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      unique case ({push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== design/ildr_back.sv =====
// Emitter: sends each queued byte, preceded by ".0" when tagged.
`timescale 1ns / 1ps

module ildr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  ildr_pkg::item_t q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_last
);

  ildr_pkg::phase_t phase_r, phase_nxt;
  logic             fire;

  assign out_valid = q_valid;
  assign fire      = out_valid && out_ready;
  assign q_pop     = fire && out_last;

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        ildr_pkg::PH_FIRST:  phase_nxt = q_item.expand ? ildr_pkg::PH_SECOND
                                                       : ildr_pkg::PH_FIRST;
        ildr_pkg::PH_SECOND: phase_nxt = ildr_pkg::PH_THIRD;
        ildr_pkg::PH_THIRD:  phase_nxt = ildr_pkg::PH_FIRST;
        default:             phase_nxt = ildr_pkg::PH_FIRST;
      endcase
    end
  end

  always_comb begin
    out_char = q_item.ch;
    out_last = 1'b1;
    if (q_item.expand) begin
      unique case (phase_r)
        ildr_pkg::PH_FIRST: begin
          out_char = ildr_pkg::CH_DOT;
          out_last = 1'b0;
        end
        ildr_pkg::PH_SECOND: begin
          out_char = ildr_pkg::CH_ZERO;
          out_last = 1'b0;
        end
        default: begin
          out_char = q_item.ch;
          out_last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) phase_r <= ildr_pkg::PH_FIRST;
    else        phase_r <= phase_nxt;
  end

  a_mid_needs_expand: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != ildr_pkg::PH_FIRST) |-> (q_valid && q_item.expand))
    else $error("emitter mid-sequence without a tagged head");

  a_stall_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (phase_r == $past(phase_r)))
    else $error("phase moved during stall");

  a_sequence_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !out_last) |=> (out_valid && q_item.expand))
    else $error("expansion sequence broken");

endmodule
